>>> hw/rtl/imm_pkg.sv
// Shared types, widths and codes for the int8 matrix multiply block.
// No dependencies; compiled first.
`default_nettype none

package imm_pkg;

    // Default storage bounds
    localparam int MAX_ROWS_DEF  = 16;
    localparam int MAX_DEPTH_DEF = 64;
    localparam int MAX_COLS_DEF  = 16;

    // Field widths
    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int INNER_W = 6;
    localparam int ELEM_W  = 8;
    localparam int SUM_W   = 22;
    localparam int PROD_W  = 2 * ELEM_W;

    // Config register widths and port
    localparam int DEPTH_W    = 7;
    localparam int ROWS_W     = 5;
    localparam int COLS_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

    // Config reset values
    localparam logic [DEPTH_W-1:0] DEPTH_RST = 7'd64;
    localparam logic [ROWS_W-1:0]  ROWS_RST  = 5'd16;
    localparam logic [COLS_W-1:0]  COLS_RST  = 5'd16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

    // Result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // Controller -> datapath
    typedef struct packed {
        logic               wr_a;      // store element into A
        logic               wr_b;      // store element into B
        logic               start;     // latch row/col bases, clear accumulator
        logic               issue;     // read pair k
        logic [DEPTH_W-1:0] k;
        logic               load_out;  // load result register
        logic               sum_sel;   // 1: accumulator, 0: zero
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic busy;                    // MAC pipeline still holds pairs
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/imm_ifs.sv
// Valid/ready channel interfaces: input items, results, config writes.
// Depends on imm_pkg.
`default_nettype none

interface imm_item_if;
    logic                               valid;
    logic                               ready;
    logic [imm_pkg::OP_W-1:0]           op;
    logic [imm_pkg::IDX_W-1:0]          row_index;
    logic [imm_pkg::IDX_W-1:0]          col_index;
    logic [imm_pkg::INNER_W-1:0]        inner_index;
    logic signed [imm_pkg::ELEM_W-1:0]  element;

    modport source (output valid, op, row_index, col_index, inner_index, element,
                    input ready);
    modport sink   (input valid, op, row_index, col_index, inner_index, element,
                    output ready);
endinterface

interface imm_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [imm_pkg::SUM_W-1:0]   dot_sum;
    logic                               status;

    modport source (output valid, dot_sum, status, input ready);
    modport sink   (input valid, dot_sum, status, output ready);
endinterface

interface imm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [imm_pkg::CFG_IDX_W-1:0]      index;
    logic [imm_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/imm_datapath.sv
// Datapath: A/B element memories, shared multiply-accumulate pipeline, result sum register.
// Depends on imm_pkg; driven by imm_ctrl commands.
`default_nettype none

module imm_datapath #(
    parameter int MAX_ROWS  = imm_pkg::MAX_ROWS_DEF,
    parameter int MAX_DEPTH = imm_pkg::MAX_DEPTH_DEF,
    parameter int MAX_COLS  = imm_pkg::MAX_COLS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire imm_pkg::t_dp_cmd              i_cmd,
    output imm_pkg::t_dp_stat                  o_stat,
    input  wire [imm_pkg::IDX_W-1:0]           i_row_index,
    input  wire [imm_pkg::IDX_W-1:0]           i_col_index,
    input  wire [imm_pkg::INNER_W-1:0]         i_inner_index,
    input  wire signed [imm_pkg::ELEM_W-1:0]   i_element,
    output logic signed [imm_pkg::SUM_W-1:0]   o_dot_sum
);

    localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
    localparam int B_DEPTH = MAX_COLS * MAX_DEPTH;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int EW      = imm_pkg::ELEM_W;
    localparam int PW      = imm_pkg::PROD_W;
    localparam int SW      = imm_pkg::SUM_W;

    logic [EW-1:0] r_a_mem [A_DEPTH];
    logic [EW-1:0] r_b_mem [B_DEPTH];

    logic [A_AW-1:0]      r_a_base;
    logic [B_AW-1:0]      r_b_base;
    logic [A_AW-1:0]      a_wr_addr, a_rd_addr;
    logic [B_AW-1:0]      b_wr_addr, b_rd_addr;
    logic [EW-1:0]        r_a_q, r_b_q;
    logic                 r_v1, r_v2;
    logic signed [PW-1:0] r_prod;
    logic [SW-1:0]        r_acc;
    logic [SW-1:0]        r_dot;

    assign a_wr_addr = A_AW'(int'(i_row_index) * MAX_DEPTH + int'(i_inner_index));
    assign b_wr_addr = B_AW'(int'(i_col_index) * MAX_DEPTH + int'(i_inner_index));
    assign a_rd_addr = r_a_base + A_AW'(i_cmd.k);
    assign b_rd_addr = r_b_base + B_AW'(i_cmd.k);

    // Memories: at most one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a) begin
            r_a_mem[a_wr_addr] <= i_element;
        end
        r_a_q <= r_a_mem[a_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b) begin
            r_b_mem[b_wr_addr] <= i_element;
        end
        r_b_q <= r_b_mem[b_rd_addr];
    end

    // Row/column bases, product stage and result sum register (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_a_base <= A_AW'(int'(i_row_index) * MAX_DEPTH);
            r_b_base <= B_AW'(int'(i_col_index) * MAX_DEPTH);
        end
        r_prod <= $signed(r_a_q) * $signed(r_b_q);
        if (i_cmd.load_out) begin
            r_dot <= i_cmd.sum_sel ? r_acc : '0;
        end
    end

    // Pipeline valids and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cmd.start) begin
                r_acc <= '0;
            end else if (r_v2) begin
                r_acc <= r_acc + {{(SW-PW){r_prod[PW-1]}}, r_prod};
            end
        end
    end

    assign o_stat.busy = r_v1 | r_v2;
    assign o_dot_sum   = r_dot;

endmodule

`default_nettype wire

>>> hw/rtl/imm_ctrl.sv
// Controller: config registers, range checks, compute sequencer, result valid/status.
// Depends on imm_pkg; commands imm_datapath.
`default_nettype none

module imm_ctrl #(
    parameter int MAX_ROWS  = imm_pkg::MAX_ROWS_DEF,
    parameter int MAX_DEPTH = imm_pkg::MAX_DEPTH_DEF,
    parameter int MAX_COLS  = imm_pkg::MAX_COLS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_item_valid,
    output logic                               o_item_ready,
    input  wire [imm_pkg::OP_W-1:0]            i_op,
    input  wire [imm_pkg::IDX_W-1:0]           i_row_index,
    input  wire [imm_pkg::IDX_W-1:0]           i_col_index,
    input  wire [imm_pkg::INNER_W-1:0]         i_inner_index,
    output logic                               o_res_valid,
    input  wire                                i_res_ready,
    output logic                               o_status,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire [imm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [imm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output imm_pkg::t_dp_cmd                   o_cmd,
    input  wire imm_pkg::t_dp_stat             i_stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    localparam int DW = imm_pkg::DEPTH_W;
    localparam int RW = imm_pkg::ROWS_W;
    localparam int CW = imm_pkg::COLS_W;

    logic [1:0]    r_state, n_state;
    logic [DW-1:0] r_k, n_k;
    logic [DW-1:0] r_depth;
    logic [RW-1:0] r_rows;
    logic [CW-1:0] r_cols;
    logic          r_res_valid, n_res_valid;
    logic          r_status, n_status;

    logic [DW-1:0] kk;
    logic [RW-1:0] mm;
    logic [CW-1:0] nn;
    logic          accept;
    logic          row_ok, col_ok, inner_ok;

    // Sizes above the storage bound act as the bound
    assign kk = (int'(r_depth) > MAX_DEPTH) ? DW'(MAX_DEPTH) : r_depth;
    assign mm = (int'(r_rows)  > MAX_ROWS)  ? RW'(MAX_ROWS)  : r_rows;
    assign nn = (int'(r_cols)  > MAX_COLS)  ? CW'(MAX_COLS)  : r_cols;

    assign row_ok   = RW'(i_row_index) < mm;
    assign col_ok   = CW'(i_col_index) < nn;
    assign inner_ok = DW'(i_inner_index) < kk;

    assign o_item_ready = (r_state == S_IDLE) && (!r_res_valid || i_res_ready);
    assign accept       = i_item_valid && o_item_ready;
    // Sizes hold still while a compute walks them
    assign o_cfg_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_res_valid = r_res_valid && !i_res_ready;
        n_status    = r_status;
        o_cmd       = '0;
        o_cmd.k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        imm_pkg::OP_WRITE_A: begin
                            o_cmd.wr_a     = row_ok && inner_ok;
                            o_cmd.load_out = 1'b1;
                            n_res_valid    = 1'b1;
                            n_status       = (row_ok && inner_ok) ? imm_pkg::STATUS_OK
                                                                  : imm_pkg::STATUS_ERR;
                        end
                        imm_pkg::OP_WRITE_B: begin
                            o_cmd.wr_b     = col_ok && inner_ok;
                            o_cmd.load_out = 1'b1;
                            n_res_valid    = 1'b1;
                            n_status       = (col_ok && inner_ok) ? imm_pkg::STATUS_OK
                                                                  : imm_pkg::STATUS_ERR;
                        end
                        imm_pkg::OP_COMPUTE: begin
                            if (row_ok && col_ok) begin
                                o_cmd.start = 1'b1;
                                n_k         = '0;
                                n_state     = S_RUN;
                            end else begin
                                o_cmd.load_out = 1'b1;
                                n_res_valid    = 1'b1;
                                n_status       = imm_pkg::STATUS_ERR;
                            end
                        end
                        default: begin
                            o_cmd.load_out = 1'b1;
                            n_res_valid    = 1'b1;
                            n_status       = imm_pkg::STATUS_ERR;
                        end
                    endcase
                end
            end
            S_RUN: begin
                if (r_k != kk) begin
                    o_cmd.issue = 1'b1;
                    n_k         = r_k + 1'b1;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.sum_sel  = 1'b1;
                    n_res_valid    = 1'b1;
                    n_status       = imm_pkg::STATUS_OK;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_res_valid <= 1'b0;
            r_status    <= imm_pkg::STATUS_OK;
            r_depth     <= imm_pkg::DEPTH_RST;
            r_rows      <= imm_pkg::ROWS_RST;
            r_cols      <= imm_pkg::COLS_RST;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_res_valid <= n_res_valid;
            r_status    <= n_status;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    imm_pkg::CFG_DEPTH: r_depth <= DW'(i_cfg_data);
                    imm_pkg::CFG_ROWS:  r_rows  <= RW'(i_cfg_data);
                    imm_pkg::CFG_COLS:  r_cols  <= CW'(i_cfg_data);
                    default: ;
                endcase
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_status    = r_status;

    // No new item while a compute is in flight
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_item_ready)
        else $error("item taken while compute in flight");

    // Reads stay inside the configured depth
    a_issue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> (r_k < kk))
        else $error("read issued past depth");

    // Finished compute presents an ok result next cycle
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && !i_stat.busy) |=> (r_res_valid && r_status == imm_pkg::STATUS_OK))
        else $error("compute finished without result");

    // Result register is empty whenever a compute begins
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> !r_res_valid)
        else $error("compute started over pending result");

endmodule

`default_nettype wire

>>> hw/rtl/int8_matrix_multiply.sv
// A write (A or B element) or a rejected item gives its result the cycle after the transfer.
// A compute item issues K reads in RUN (K being the effective depth) to one shared
// multiply-accumulate fed one A/B pair per cycle from the element memories, and DRAIN loads
// the result once that pipeline is empty. One item is in work at a time. Reset (synchronous,
// active low) clears control and sets depth/rows/cols to 64/16/16; memories are not cleared.
// Top level; depends on imm_pkg, imm_ifs, imm_ctrl, imm_datapath.
`default_nettype none

module int8_matrix_multiply #(
    parameter int MAX_ROWS  = imm_pkg::MAX_ROWS_DEF,
    parameter int MAX_DEPTH = imm_pkg::MAX_DEPTH_DEF,
    parameter int MAX_COLS  = imm_pkg::MAX_COLS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    imm_item_if.sink       i_item,
    imm_result_if.source   o_result,
    imm_cfg_if.sink        i_cfg
);

    // Command/status bundle between sequencer and datapath
    imm_pkg::t_dp_cmd  cmd;
    imm_pkg::t_dp_stat stat;

    // Controller: range checks against the clamped sizes, config writes
    // (ready only while no compute is in flight), and the compute
    // sequence IDLE -> RUN (K read issues) -> DRAIN (pipeline flush).
    imm_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_COLS  (MAX_COLS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (i_item.valid),
        .o_item_ready  (i_item.ready),
        .i_op          (i_item.op),
        .i_row_index   (i_item.row_index),
        .i_col_index   (i_item.col_index),
        .i_inner_index (i_item.inner_index),
        .o_res_valid   (o_result.valid),
        .i_res_ready   (o_result.ready),
        .o_status      (o_result.status),
        .i_cfg_valid   (i_cfg.valid),
        .o_cfg_ready   (i_cfg.ready),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    // Datapath: memory read -> product register -> 22-bit wrapping accumulator.
    // The result sum register sits here, next to the accumulator.
    imm_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_COLS  (MAX_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_row_index   (i_item.row_index),
        .i_col_index   (i_item.col_index),
        .i_inner_index (i_item.inner_index),
        .i_element     (i_item.element),
        .o_dot_sum     (o_result.dot_sum)
    );

endmodule

`default_nettype wire

>>> tb/tb_int8_matrix_multiply.sv
`timescale 1ns / 1ps
// Self-checking testbench for int8_matrix_multiply: a table of directed items, then random
// load/compute sequences, checked against a predictor of the A/B element stores.
// Depends on imm_pkg, imm_ifs and the int8_matrix_multiply RTL.

module tb_int8_matrix_multiply;

    localparam int MAX_R = imm_pkg::MAX_ROWS_DEF;
    localparam int MAX_K = imm_pkg::MAX_DEPTH_DEF;
    localparam int MAX_C = imm_pkg::MAX_COLS_DEF;

    // op code the block leaves unused; it must be rejected
    localparam logic [imm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_TARGET   = 1850;
    localparam int IDLE_LIMIT    = 3000;  // cycles without any transfer before giving up
    localparam int SETTLE_CYCLES = 8;     // idle margin after the last owed result
    localparam int PRINT_CAP     = 30;

    // fill kinds for a loaded row or column
    localparam int FILL_RANDOM = 0;
    localparam int FILL_MIN    = 1;
    localparam int FILL_MAX    = 2;
    localparam int FILL_CORNER = 3;

    typedef struct packed {
        logic [imm_pkg::OP_W-1:0]          op;
        logic [imm_pkg::IDX_W-1:0]         row;
        logic [imm_pkg::IDX_W-1:0]         col;
        logic [imm_pkg::INNER_W-1:0]       inner;
        logic signed [imm_pkg::ELEM_W-1:0] elem;
    } t_item;

    typedef struct packed {
        logic signed [imm_pkg::SUM_W-1:0] dot_sum;
        logic                             status;
    } t_dot_result;

    // one row of the directed table: an item or a register write
    typedef struct {
        bit                             is_cfg;
        logic [imm_pkg::CFG_IDX_W-1:0]  cfg_idx;
        logic [imm_pkg::CFG_DATA_W-1:0] cfg_data;
        t_item                          it;
        bit                             typed;  // want is given literally
        t_dot_result                    want;
    } t_stim_row;

    logic clk;
    logic rst_n;

    imm_item_if   item_ch ();
    imm_result_if res_ch ();
    imm_cfg_if    cfg_ch ();

    int8_matrix_multiply dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // ---------------------------------------------------------------------------------------
    // Shadow of the block: element stores, written flags and the size registers
    // ---------------------------------------------------------------------------------------
    logic signed [imm_pkg::ELEM_W-1:0] a_elem [MAX_R][MAX_K];
    logic signed [imm_pkg::ELEM_W-1:0] b_elem [MAX_C][MAX_K];
    bit                                a_set  [MAX_R][MAX_K];
    bit                                b_set  [MAX_C][MAX_K];
    logic [imm_pkg::DEPTH_W-1:0]       depth_reg = imm_pkg::DEPTH_RST;
    logic [imm_pkg::ROWS_W-1:0]        rows_reg  = imm_pkg::ROWS_RST;
    logic [imm_pkg::COLS_W-1:0]        cols_reg  = imm_pkg::COLS_RST;

    t_dot_result dot_results_due [$];  // oldest first
    t_stim_row   stim_rows [$];

    int  n_errors;
    int  n_items;
    int  n_compute;
    int  n_reject;
    int  n_cfg;
    int  n_checked;
    int  idle_cycles;
    int  rx_hold;
    bit  calm;  // no idling on either side while set

    // ---------------------------------------------------------------------------------------
    // Clock
    // ---------------------------------------------------------------------------------------
    initial clk = 1'b0;
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Effective sizes: oversized registers act as the storage bound
    function automatic int eff_depth();
        return (int'(depth_reg) > MAX_K) ? MAX_K : int'(depth_reg);
    endfunction

    function automatic int eff_rows();
        return (int'(rows_reg) > MAX_R) ? MAX_R : int'(rows_reg);
    endfunction

    function automatic int eff_cols();
        return (int'(cols_reg) > MAX_C) ? MAX_C : int'(cols_reg);
    endfunction

    // Applies one accepted item to the shadow stores and returns its result.
    // Sum is accumulated in 32 bits and cut to the 22-bit result field.
    function automatic t_dot_result matmul_step(t_item it);
        t_dot_result r;
        int          kk;
        int          acc;
        kk       = eff_depth();
        acc      = 0;
        r.status = imm_pkg::STATUS_ERR;
        case (it.op)
            imm_pkg::OP_WRITE_A: begin
                if (it.row < eff_rows() && it.inner < kk) begin
                    a_elem[it.row][it.inner] = it.elem;
                    a_set[it.row][it.inner]  = 1'b1;
                    r.status = imm_pkg::STATUS_OK;
                end
            end
            imm_pkg::OP_WRITE_B: begin
                if (it.col < eff_cols() && it.inner < kk) begin
                    b_elem[it.col][it.inner] = it.elem;
                    b_set[it.col][it.inner]  = 1'b1;
                    r.status = imm_pkg::STATUS_OK;
                end
            end
            imm_pkg::OP_COMPUTE: begin
                if (it.row < eff_rows() && it.col < eff_cols()) begin
                    for (int k = 0; k < kk; k++)
                        acc += int'(a_elem[it.row][k]) * int'(b_elem[it.col][k]);
                    r.status = imm_pkg::STATUS_OK;
                end
            end
            default: ;  // unused op: nothing changes
        endcase
        r.dot_sum = acc[imm_pkg::SUM_W-1:0];
        return r;
    endfunction

    // True when every element a compute on (r, c) reads has been written
    function automatic bit pair_ready(int r, int c);
        for (int k = 0; k < eff_depth(); k++)
            if (!a_set[r][k] || !b_set[c][k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit pick_ready(output int r, output int c);
        for (int t = 0; t < 12; t++) begin
            r = $urandom_range(0, eff_rows() - 1);
            c = $urandom_range(0, eff_cols() - 1);
            if (pair_ready(r, c))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Gap length in cycles: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [imm_pkg::ELEM_W-1:0] elem_of(int kind);
        logic [1:0] pick;
        pick = 2'($urandom_range(0, 3));
        case (kind)
            FILL_MIN:    return -8'sd128;
            FILL_MAX:    return 8'sd127;
            FILL_CORNER: begin
                case (pick)
                    2'd0:    return -8'sd128;
                    2'd1:    return 8'sd127;
                    2'd2:    return -8'sd1;
                    default: return 8'sd0;
                endcase
            end
            default:     return (imm_pkg::ELEM_W)'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_item make_item(logic [imm_pkg::OP_W-1:0] op, int row, int col,
                                        int inner, int elem);
        t_item it;
        it.op    = op;
        it.row   = row[imm_pkg::IDX_W-1:0];
        it.col   = col[imm_pkg::IDX_W-1:0];
        it.inner = inner[imm_pkg::INNER_W-1:0];
        it.elem  = elem[imm_pkg::ELEM_W-1:0];
        return it;
    endfunction

    // Directed table builders
    function automatic void dir_item(logic [imm_pkg::OP_W-1:0] op, int row, int col, int inner,
                                     int elem, bit typed, int sum, logic status);
        t_stim_row s;
        s.is_cfg       = 1'b0;
        s.cfg_idx      = '0;
        s.cfg_data     = '0;
        s.it           = make_item(op, row, col, inner, elem);
        s.typed        = typed;
        s.want.dot_sum = sum[imm_pkg::SUM_W-1:0];
        s.want.status  = status;
        stim_rows.push_back(s);
    endfunction

    function automatic void dir_cfg(logic [imm_pkg::CFG_IDX_W-1:0] idx, int data);
        t_stim_row s;
        s.is_cfg   = 1'b1;
        s.cfg_idx  = idx;
        s.cfg_data = data[imm_pkg::CFG_DATA_W-1:0];
        s.it       = '0;
        s.typed    = 1'b0;
        s.want     = '0;
        stim_rows.push_back(s);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (n_errors < PRINT_CAP)
            $display("MISMATCH @%0t: %s got %0d want %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    // ---------------------------------------------------------------------------------------
    // Item sender. Called at a falling edge; returns at the falling edge after the
    // transfer with valid still high, so back-to-back items need no dead cycle.
    // ---------------------------------------------------------------------------------------
    task automatic send_item(t_item it, bit typed, t_dot_result want);
        int          gap;
        t_dot_result res;
        gap = pick_gap();
        if (gap > 0) begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid       = 1'b1;
        item_ch.op          = it.op;
        item_ch.row_index   = it.row;
        item_ch.col_index   = it.col;
        item_ch.inner_index = it.inner;
        item_ch.element     = it.elem;
        do @(posedge clk); while (!item_ch.ready);
        res = matmul_step(it);
        if (typed)
            res = want;
        n_items++;
        if (it.op == imm_pkg::OP_COMPUTE)
            n_compute++;
        if (res.status == imm_pkg::STATUS_ERR)
            n_reject++;
        // queue it after the edge so the result monitor never races the push
        @(negedge clk);
        dot_results_due.push_back(res);
    endtask

    // Stop sending and wait until every owed result has come back
    task automatic drain_results();
        item_ch.valid = 1'b0;
        while (dot_results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Register write, only ever done with the block idle
    task automatic write_reg(logic [imm_pkg::CFG_IDX_W-1:0] idx,
                             logic [imm_pkg::CFG_DATA_W-1:0] data);
        drain_results();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            imm_pkg::CFG_DEPTH: depth_reg = data[imm_pkg::DEPTH_W-1:0];
            imm_pkg::CFG_ROWS:  rows_reg  = data[imm_pkg::ROWS_W-1:0];
            imm_pkg::CFG_COLS:  cols_reg  = data[imm_pkg::COLS_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Well-formed sequence: load a row of A and a column of B over the whole depth when the
    // pair is not fully loaded or by chance, then compute it and up to two other loaded pairs.
    task automatic fill_and_compute();
        int kk;
        int r;
        int c;
        int r2;
        int c2;
        int start;
        int ka;
        int kb;
        int n;
        kk = eff_depth();
        r  = $urandom_range(0, eff_rows() - 1);
        c  = $urandom_range(0, eff_cols() - 1);
        if (!pair_ready(r, c) || $urandom_range(0, 2) == 0) begin
            ka    = $urandom_range(FILL_RANDOM, FILL_CORNER);
            kb    = ($urandom_range(0, 1) == 0) ? ka : $urandom_range(FILL_RANDOM, FILL_CORNER);
            start = $urandom_range(0, kk - 1);
            for (int i = 0; i < kk; i++)
                send_item(make_item(imm_pkg::OP_WRITE_A, r, $urandom_range(0, 15),
                                    (start + i) % kk, elem_of(ka)), 1'b0, '0);
            for (int i = 0; i < kk; i++)
                send_item(make_item(imm_pkg::OP_WRITE_B, $urandom_range(0, 15), c,
                                    (start + i) % kk, elem_of(kb)), 1'b0, '0);
        end
        send_item(make_item(imm_pkg::OP_COMPUTE, r, c, $urandom_range(0, 63),
                            $urandom_range(0, 255)), 1'b0, '0);
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            if (pick_ready(r2, c2))
                send_item(make_item(imm_pkg::OP_COMPUTE, r2, c2, $urandom_range(0, 63),
                                    $urandom_range(0, 255)), 1'b0, '0);
    endtask

    // Any field value; a compute that would read unwritten elements is steered to a
    // loaded pair, or turned into a write when there is none.
    task automatic noise_item();
        t_item it;
        int    r;
        int    c;
        it = make_item((imm_pkg::OP_W)'($urandom_range(0, 3)), $urandom_range(0, 15),
                       $urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 255));
        if (it.op == imm_pkg::OP_COMPUTE && it.row < eff_rows() && it.col < eff_cols()
            && !pair_ready(it.row, it.col)) begin
            if (pick_ready(r, c)) begin
                it.row = r[imm_pkg::IDX_W-1:0];
                it.col = c[imm_pkg::IDX_W-1:0];
            end else begin
                it.op = imm_pkg::OP_WRITE_A;
            end
        end
        send_item(it, 1'b0, '0);
    endtask

    // ---------------------------------------------------------------------------------------
    // Result side: random back-pressure driven at the falling edge
    // ---------------------------------------------------------------------------------------
    initial begin
        res_ch.ready = 1'b0;
        rx_hold      = 0;
        forever begin
            @(negedge clk);
            if (rx_hold > 0) begin
                res_ch.ready = 1'b0;
                rx_hold--;
            end else begin
                res_ch.ready = 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    rx_hold = pick_gap();
            end
        end
    end

    // Each result transfer is checked field by field against the oldest owed result
    always @(posedge clk) begin
        t_dot_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            n_checked++;
            if (dot_results_due.size() == 0) begin
                report_mismatch("result with nothing owed, dot_sum", int'(res_ch.dot_sum), 0);
            end else begin
                want = dot_results_due.pop_front();
                if (res_ch.dot_sum !== want.dot_sum)
                    report_mismatch("dot_sum", int'(res_ch.dot_sum), int'(want.dot_sum));
                if (res_ch.status !== want.status)
                    report_mismatch("status", int'(res_ch.status), int'(want.status));
            end
        end
    end

    // Watchdog: too long without any transfer on any channel means the block is stuck
    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: %0d cycles without a transfer, %0d results owed",
                     idle_cycles, dot_results_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------------
    initial begin
        int d;
        int m;
        int n;
        int round;
        int round_end;
        int pick;
        bit can_compute;

        rst_n               = 1'b0;
        calm                = 1'b0;
        item_ch.valid       = 1'b0;
        item_ch.op          = imm_pkg::OP_WRITE_A;
        item_ch.row_index   = '0;
        item_ch.col_index   = '0;
        item_ch.inner_index = '0;
        item_ch.element     = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = imm_pkg::CFG_DEPTH;
        cfg_ch.data         = '0;
        n_errors            = 0;
        n_items             = 0;
        n_compute           = 0;
        n_reject            = 0;
        n_cfg               = 0;
        n_checked           = 0;
        idle_cycles         = 0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // --- directed table ---
        // reset sizes 64/16/16: unused op rejected, top corners of both stores writable
        dir_item(OP_UNUSED, 15, 15, 63, -128, 1'b1, 0, imm_pkg::STATUS_ERR);
        dir_item(imm_pkg::OP_WRITE_A, 15, 0, 63, -128, 1'b1, 0, imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_WRITE_B, 0, 15, 63, 127, 1'b1, 0, imm_pkg::STATUS_OK);
        // 2 x 2 x 2 problem with extreme elements
        dir_cfg(imm_pkg::CFG_DEPTH, 2);
        dir_cfg(imm_pkg::CFG_ROWS, 2);
        dir_cfg(imm_pkg::CFG_COLS, 2);
        dir_item(imm_pkg::OP_WRITE_A, 0, 0, 0, 127, 1'b1, 0, imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_WRITE_A, 0, 0, 1, -128, 1'b1, 0, imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_WRITE_B, 0, 0, 0, 127, 1'b1, 0, imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_WRITE_B, 0, 0, 1, -128, 1'b1, 0, imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_COMPUTE, 0, 0, 0, 0, 1'b1, 127 * 127 + 128 * 128,
                 imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_WRITE_A, 1, 0, 0, -128, 1'b0, 0, imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_WRITE_A, 1, 0, 1, -128, 1'b0, 0, imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_COMPUTE, 1, 0, 0, 0, 1'b0, 0, imm_pkg::STATUS_OK);
        // indices just past the configured sizes
        dir_item(imm_pkg::OP_WRITE_A, 2, 0, 0, 1, 1'b1, 0, imm_pkg::STATUS_ERR);
        dir_item(imm_pkg::OP_WRITE_B, 0, 2, 0, 1, 1'b1, 0, imm_pkg::STATUS_ERR);
        dir_item(imm_pkg::OP_WRITE_A, 0, 0, 2, 1, 1'b1, 0, imm_pkg::STATUS_ERR);
        dir_item(imm_pkg::OP_COMPUTE, 2, 0, 0, 0, 1'b1, 0, imm_pkg::STATUS_ERR);
        dir_item(imm_pkg::OP_COMPUTE, 0, 2, 0, 0, 1'b1, 0, imm_pkg::STATUS_ERR);
        // zero depth: writes fail, compute succeeds with an empty sum
        dir_cfg(imm_pkg::CFG_DEPTH, 0);
        dir_item(imm_pkg::OP_WRITE_A, 0, 0, 0, 7, 1'b1, 0, imm_pkg::STATUS_ERR);
        dir_item(imm_pkg::OP_COMPUTE, 0, 0, 0, 0, 1'b1, 0, imm_pkg::STATUS_OK);
        // zero rows: anything using a row fails
        dir_cfg(imm_pkg::CFG_ROWS, 0);
        dir_item(imm_pkg::OP_COMPUTE, 0, 0, 0, 0, 1'b1, 0, imm_pkg::STATUS_ERR);
        // oversized depth acts as 64; rows still zero
        dir_cfg(imm_pkg::CFG_DEPTH, 100);
        dir_item(imm_pkg::OP_WRITE_B, 0, 1, 63, -1, 1'b1, 0, imm_pkg::STATUS_OK);
        dir_item(imm_pkg::OP_WRITE_A, 0, 0, 63, -1, 1'b1, 0, imm_pkg::STATUS_ERR);
        // oversized rows act as 16
        dir_cfg(imm_pkg::CFG_ROWS, 20);
        dir_item(imm_pkg::OP_WRITE_A, 15, 0, 63, 3, 1'b1, 0, imm_pkg::STATUS_OK);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg)
                write_reg(stim_rows[i].cfg_idx, stim_rows[i].cfg_data);
            else
                send_item(stim_rows[i].it, stim_rows[i].typed, stim_rows[i].want);
        end

        // --- random rounds, each under its own register setting ---
        round = 0;
        while (n_items < ITEM_TARGET) begin
            case (round)
                0: begin d = 64;  m = 16; n = 16; end
                1: begin d = 1;   m = 1;  n = 1;  end
                2: begin d = 0;   m = 0;  n = 0;  end
                3: begin d = 127; m = 31; n = 31; end
                default: begin
                    pick = $urandom_range(0, 99);
                    if (pick < 60)
                        d = $urandom_range(1, 8);
                    else if (pick < 85)
                        d = $urandom_range(9, 40);
                    else
                        d = $urandom_range(41, 127);
                    m = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                                     : $urandom_range(17, 31);
                    n = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 16)
                                                     : $urandom_range(17, 31);
                end
            endcase
            write_reg(imm_pkg::CFG_DEPTH, d[imm_pkg::CFG_DATA_W-1:0]);
            write_reg(imm_pkg::CFG_ROWS, m[imm_pkg::CFG_DATA_W-1:0]);
            write_reg(imm_pkg::CFG_COLS, n[imm_pkg::CFG_DATA_W-1:0]);
            calm        = ($urandom_range(0, 3) == 0);
            can_compute = eff_depth() > 0 && eff_rows() > 0 && eff_cols() > 0;
            round_end   = n_items + $urandom_range(80, 160);
            while (n_items < round_end && n_items < ITEM_TARGET) begin
                // occasionally hold the sender until the block has emptied
                if ($urandom_range(0, 49) == 0)
                    drain_results();
                if (can_compute && $urandom_range(0, 9) < 7)
                    fill_and_compute();
                else
                    noise_item();
            end
            round++;
        end

        drain_results();
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d items (%0d computes, %0d rejected) over %0d register writes",
                 n_items, n_compute, n_reject, n_cfg);
        $display("in %0d register settings; %0d results checked, %0d mismatches",
                 round + 1, n_checked, n_errors);
        if (n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/imm_pkg.sv
hw/rtl/imm_ifs.sv
hw/rtl/imm_datapath.sv
hw/rtl/imm_ctrl.sv
hw/rtl/int8_matrix_multiply.sv
tb/tb_int8_matrix_multiply.sv
